[src/tlrb_pkg.sv]
package tlrb_pkg;

	localparam int unsigned TERMINALS_DEF  = 4;
	localparam int unsigned LINE_DEPTH_DEF = 256;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [1:0] terminal;
		logic [7:0] char_in;
		logic       call_final;
	} req_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       done_res;
		logic       line_ready;
		logic [8:0] fill_level;
		logic       final_out;
	} rsp_t;

endpackage

[src/tlrb_ram.sv]
module tlrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/terminal_line_ring_buffers.sv]
// Per-terminal character rings sharing one byte store of TERMINALS x LINE_DEPTH
// entries. Each request pushes or pops one byte on one terminal; every request
// yields exactly one response carrying the popped byte, a done flag, the fill
// level and whether a newline is held. One request is taken every clock cycle
// while the response side keeps up. A response passes through the stage-one
// registers, then the output register: at acceptance pointers and counts are
// updated and the store is accessed (registered read); when stage one advances,
// the popped byte is folded into the newline count and the output register
// is loaded. A stalled response holds the input after one further request.
// A push to a full ring or a pop from an empty one leaves state untouched and
// reports done_res low; a terminal index at or above TERMINALS is ignored and
// answered with zero byte, flags and fill level, final_out echoing call_final.
module terminal_line_ring_buffers #(
	parameter int unsigned TERMINALS  = tlrb_pkg::TERMINALS_DEF,
	parameter int unsigned LINE_DEPTH = tlrb_pkg::LINE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tlrb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tlrb_pkg::rsp_t rsp
);
	import tlrb_pkg::*;

	localparam int unsigned TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
	localparam int unsigned PW    = $clog2(LINE_DEPTH);
	localparam int unsigned CW    = $clog2(LINE_DEPTH + 1);
	localparam int unsigned DEPTH = TERMINALS * LINE_DEPTH;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PW-1:0] head_q [TERMINALS];
	logic [PW-1:0] tail_q [TERMINALS];
	logic [CW-1:0] held_q [TERMINALS];
	logic [CW-1:0] nl_q   [TERMINALS];

	// accept stage
	logic          fire;
	logic          t_ok;
	logic [TW-1:0] tix;
	logic          is_push;
	logic [CW-1:0] held_cur;
	logic [CW-1:0] held_nx;
	logic [PW-1:0] head_cur;
	logic [PW-1:0] tail_cur;
	logic          push_ok;
	logic          pop_ok;
	logic [AW-1:0] base;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;

	// second stage
	logic          valid_s1;
	logic          t_ok_s1;
	logic [TW-1:0] tix_s1;
	logic          push_ok_s1;
	logic          pop_ok_s1;
	logic [7:0]    char_s1;
	logic [8:0]    fill_s1;
	logic          final_s1;
	logic          s1_adv;
	logic [CW-1:0] nl_cur;
	logic [CW-1:0] nl_nx;
	rsp_t          rsp_nx;

	logic rsp_valid_q;
	rsp_t rsp_q;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] pos);
		logic [PW-1:0] res;
		res = (pos == PW'(LINE_DEPTH - 1)) ? '0 : pos + 1'b1;
		return res;
	endfunction

	assign s1_adv    = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || s1_adv;
	assign fire      = req_valid && req_ready;

	always_comb begin
		t_ok     = int'(req.terminal) < TERMINALS;
		tix      = TW'(req.terminal);
		is_push  = req.opcode == OP_PUSH;
		held_cur = t_ok ? held_q[tix] : '0;
		head_cur = t_ok ? head_q[tix] : '0;
		tail_cur = t_ok ? tail_q[tix] : '0;
		push_ok  = t_ok && is_push && (held_cur != CW'(LINE_DEPTH));
		pop_ok   = t_ok && !is_push && (held_cur != '0);
		if (push_ok) begin
			held_nx = held_cur + 1'b1;
		end else if (pop_ok) begin
			held_nx = held_cur - 1'b1;
		end else begin
			held_nx = held_cur;
		end
		base  = AW'(tix) * AW'(LINE_DEPTH);
		waddr = base + AW'(tail_cur);
		raddr = base + AW'(head_cur);
	end

	tlrb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (fire && push_ok),
		.waddr (waddr),
		.wdata (req.char_in),
		.re    (fire && pop_ok),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERMINALS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				held_q[i] <= '0;
			end
		end else if (fire && t_ok) begin
			held_q[tix] <= held_nx;
			if (push_ok) begin
				tail_q[tix] <= next_pos(tail_cur);
			end
			if (pop_ok) begin
				head_q[tix] <= next_pos(head_cur);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			t_ok_s1    <= t_ok;
			tix_s1     <= tix;
			push_ok_s1 <= push_ok;
			pop_ok_s1  <= pop_ok;
			char_s1    <= req.char_in;
			fill_s1    <= 9'(held_nx);
			final_s1   <= req.call_final;
		end
	end

	// newline count follows the popped byte, so it is updated in the second stage
	always_comb begin
		nl_cur = t_ok_s1 ? nl_q[tix_s1] : '0;
		nl_nx  = nl_cur;
		if (push_ok_s1 && char_s1 == NEWLINE_CHAR) begin
			nl_nx = nl_cur + 1'b1;
		end else if (pop_ok_s1 && rdata == NEWLINE_CHAR && nl_cur != '0) begin
			nl_nx = nl_cur - 1'b1;
		end
		rsp_nx.char_out   = pop_ok_s1 ? rdata : 8'h00;
		rsp_nx.done_res   = push_ok_s1 || pop_ok_s1;
		rsp_nx.line_ready = t_ok_s1 && (nl_nx != '0);
		rsp_nx.fill_level = fill_s1;
		rsp_nx.final_out  = final_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERMINALS; i++) begin
				nl_q[i] <= '0;
			end
		end else if (valid_s1 && s1_adv && t_ok_s1) begin
			nl_q[tix_s1] <= nl_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[src/tlrb_checker.sv]
module tlrb_checker #(
	parameter int unsigned LINE_DEPTH = tlrb_pkg::LINE_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input tlrb_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input tlrb_pkg::rsp_t rsp
);
	import tlrb_pkg::*;

	localparam logic SMALL_RING = LINE_DEPTH < 512;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.done_res |-> rsp.char_out == 8'h00)
		else $error("byte returned on a request that did nothing");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && SMALL_RING |-> rsp.fill_level <= 9'(LINE_DEPTH))
		else $error("fill level above ring depth");

	a_line_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && SMALL_RING && rsp.line_ready |-> rsp.fill_level != 9'd0)
		else $error("line ready on an empty ring");

endmodule

bind terminal_line_ring_buffers tlrb_checker #(.LINE_DEPTH(LINE_DEPTH)) u_tlrb_checker (.*);
